// ===== design/scr_pkg.sv =====
// ----------------------------------------------------------------------------
// scr_pkg: shared definitions for the stroke smoother
// Defaults, register map and command codes used by the top, front and back.
// ----------------------------------------------------------------------------
package scr_pkg;

  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int COORD_BITS_DEF   = 20;

  localparam int HPW_W  = 12;
  localparam int STEP_W = 16;
  localparam logic [HPW_W-1:0]  HPW_RESET  = 12'd16;
  localparam logic [STEP_W-1:0] STEP_RESET = 16'd64;

  // register indexes (byte address = 4 * index)
  localparam logic REG_HPW  = 1'b0;
  localparam logic REG_STEP = 1'b1;

  // weight width: Q0.16 plus sign and headroom for 1.0
  localparam int WGT_W = 18;

  typedef enum logic {
    CMD_EMIT   = 1'b0,
    CMD_INTERP = 1'b1
  } cmd_kind_t;

endpackage

// ===== design/stroke_catmull_rom_smoother.sv =====
// ----------------------------------------------------------------------------
// stroke_catmull_rom_smoother: Catmull-Rom smoothing of pen strokes
// Offsets pen samples, sizes each segment and emits interpolated points.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | transaction
//  in       | in_valid/in_ready, sample_x/y, start    | one pen sample
//  out      | out_valid/out_ready, point_x/y, last    | one path point
//  cfg      | psel/penable/pwrite/paddr/pwdata/prdata | register write/read
//
// Front: the second and third samples of a stroke only fill the window, the
// first also pushes a command; later ones run three square roots (one when
// lengths are cached) plus a segment count search unless the count saturates.
// Back: a single point goes straight to the output load; an interpolated
// segment first runs a reciprocal setup, then for each point t^2, t^3, weights,
// eight multiply-accumulate steps on one shared multiplier, one output load.
// A two-entry command queue lets the front take samples while the back works.
// Reset is synchronous, active low; no clearing pass is needed.
// out_ready low holds the output register; the back stalls, the front fills
// the queue and then drops in_ready.
// ----------------------------------------------------------------------------
module stroke_catmull_rom_smoother #(
  parameter int MAX_SEGMENTS = scr_pkg::MAX_SEGMENTS_DEF,
  parameter int COORD_BITS   = scr_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_sample_x,
  input  logic signed [COORD_BITS-1:0] in_sample_y,
  input  logic                         in_stroke_start,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_point_x,
  output logic signed [COORD_BITS-1:0] out_point_y,
  output logic                         out_last_point,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int NW    = $clog2(MAX_SEGMENTS + 1);
  localparam int CMD_W = 1 + NW + 8 * COORD_BITS;

  logic [scr_pkg::HPW_W-1:0]  hpw_r;
  logic [scr_pkg::STEP_W-1:0] step_r;
  logic                       wr_en;

  logic             q_push, q_pop, q_full, q_empty;
  logic [CMD_W-1:0] q_wdata, q_rdata;

  // register file: index = paddr[2], written in the access phase
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hpw_r  <= scr_pkg::HPW_RESET;
      step_r <= scr_pkg::STEP_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        scr_pkg::REG_HPW:  hpw_r  <= pwdata[scr_pkg::HPW_W-1:0];
        scr_pkg::REG_STEP: step_r <= pwdata[scr_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      scr_pkg::REG_HPW:  prdata = 32'(hpw_r);
      scr_pkg::REG_STEP: prdata = 32'(step_r);
      default:           prdata = '0;
    endcase
  end

  scr_front #(
    .COORD_BITS(COORD_BITS), .MAX_SEGMENTS(MAX_SEGMENTS), .NW(NW), .CMD_W(CMD_W)
  ) u_front (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_sample_x, .in_sample_y, .in_stroke_start,
    .hpw(hpw_r), .step(step_r),
    .q_push, .q_data(q_wdata), .q_full
  );

  scr_cmdq #(.W(CMD_W), .DEPTH(2)) u_cmdq (
    .clk, .rst_n,
    .push(q_push), .wdata(q_wdata), .full(q_full),
    .pop(q_pop), .rdata(q_rdata), .empty(q_empty)
  );

  scr_back #(
    .COORD_BITS(COORD_BITS), .MAX_SEGMENTS(MAX_SEGMENTS), .NW(NW), .CMD_W(CMD_W)
  ) u_back (
    .clk, .rst_n,
    .q_data(q_rdata), .q_empty, .q_pop,
    .out_valid, .out_ready, .out_point_x, .out_point_y, .out_last_point
  );

endmodule

// ===== design/scr_dist.sv =====
// ----------------------------------------------------------------------------
// scr_dist: segment length unit
// Squares the two axis distances, then takes an exact floor square root,
// two radicand bits per cycle.
// ----------------------------------------------------------------------------
module scr_dist #(
  parameter int COORD_BITS = scr_pkg::COORD_BITS_DEF,
  parameter int DW         = COORD_BITS + 1,
  parameter int RW         = DW + 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  output logic                         done,
  output logic [RW-1:0]                root
);

  localparam int SQE = 2 * RW;
  localparam int CW  = $clog2(RW + 1);

  typedef enum logic [1:0] {D_IDLE, D_SQX, D_SQY, D_ROOT} dstate_t;

  dstate_t          state_r;
  logic [DW-1:0]    dx_r, dy_r;
  logic [SQE-1:0]   rad_r;
  logic [RW+1:0]    rem_r;
  logic [RW-1:0]    root_r;
  logic [CW-1:0]    cnt_r;
  logic             done_r;

  logic signed [DW-1:0] dxs, dys;
  logic [RW+1:0]        rem_sh, trial;

  assign dxs    = DW'(bx) - DW'(ax);
  assign dys    = DW'(by) - DW'(ay);
  assign rem_sh = {rem_r[RW-1:0], rad_r[SQE-1 -: 2]};
  assign trial  = {root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        D_IDLE: begin
          if (start) begin
            dx_r    <= dxs[DW-1] ? DW'(-dxs) : DW'(dxs);
            dy_r    <= dys[DW-1] ? DW'(-dys) : DW'(dys);
            state_r <= D_SQX;
          end
        end
        D_SQX: begin
          rad_r   <= SQE'(dx_r * dx_r);
          state_r <= D_SQY;
        end
        D_SQY: begin
          rad_r   <= rad_r + SQE'(dy_r * dy_r);
          rem_r   <= '0;
          root_r  <= '0;
          cnt_r   <= CW'(RW);
          state_r <= D_ROOT;
        end
        D_ROOT: begin
          rad_r <= {rad_r[SQE-3:0], 2'b00};
          if (rem_sh >= trial) begin
            rem_r  <= rem_sh - trial;
            root_r <= {root_r[RW-2:0], 1'b1};
          end else begin
            rem_r  <= rem_sh;
            root_r <= {root_r[RW-2:0], 1'b0};
          end
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CW'(1)) begin
            done_r  <= 1'b1;
            state_r <= D_IDLE;
          end
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== design/scr_front.sv =====
// ----------------------------------------------------------------------------
// scr_front: sample intake and segment classification
// Offsets samples, keeps the window and cached lengths, sizes the segment
// and queues one command per sample that yields output.
// ----------------------------------------------------------------------------
module scr_front #(
  parameter int COORD_BITS   = scr_pkg::COORD_BITS_DEF,
  parameter int MAX_SEGMENTS = scr_pkg::MAX_SEGMENTS_DEF,
  parameter int NW           = $clog2(MAX_SEGMENTS + 1),
  parameter int CMD_W        = 1 + NW + 8 * COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_sample_x,
  input  logic signed [COORD_BITS-1:0] in_sample_y,
  input  logic                         in_stroke_start,
  input  logic [scr_pkg::HPW_W-1:0]    hpw,
  input  logic [scr_pkg::STEP_W-1:0]   step,
  output logic                         q_push,
  output logic [CMD_W-1:0]             q_data,
  input  logic                         q_full
);

  localparam int CB = COORD_BITS;
  localparam int RW = CB + 2;
  localparam int KW = (NW > 1) ? $clog2(NW) : 1;
  localparam int MW = RW + NW + scr_pkg::STEP_W;
  localparam logic signed [CB:0] CMIN = {2'b11, {(CB-1){1'b0}}};

  typedef enum logic [2:0] {F_IDLE, F_LEN, F_NSAT, F_NDIV, F_DECIDE, F_PUSH} fstate_t;

  fstate_t                state_r;
  logic signed [CB-1:0]   wx_r [3];
  logic signed [CB-1:0]   wy_r [3];
  logic signed [CB-1:0]   px_r, py_r;
  logic [1:0]             held_r;
  logic                   lv_r;
  logic [RW-1:0]          cache0_r, cache1_r;
  logic [RW-1:0]          dab_r, dbc_r, dcd_r;
  logic [1:0]             sel_r;
  logic                   launch_r;
  logic [NW-1:0]          n_r;
  logic [KW-1:0]          k_r;
  logic [CMD_W-1:0]       cmd_r;

  logic signed [CB:0]     offx, offy;
  logic signed [CB-1:0]   sx, sy;
  logic [1:0]             held_eff;
  logic signed [CB-1:0]   dax, day, dbx, dby;
  logic                   dist_done;
  logic [RW-1:0]          dist_root;
  logic [scr_pkg::STEP_W-1:0] su;
  logic [NW-1:0]          trial;
  logic [MW-1:0]          sat_lim, trial_prod;
  logic [RW+4:0]          lhs20, rhs;

  assign offx = (CB+1)'(in_sample_x) - (CB+1)'(hpw);
  assign offy = (CB+1)'(in_sample_y) - (CB+1)'(hpw);
  assign sx   = (offx < CMIN) ? CMIN[CB-1:0] : offx[CB-1:0];
  assign sy   = (offy < CMIN) ? CMIN[CB-1:0] : offy[CB-1:0];
  assign held_eff = in_stroke_start ? 2'd0 : held_r;

  always_comb begin
    case (sel_r)
      2'd0:    begin dax = wx_r[0]; day = wy_r[0]; dbx = wx_r[1]; dby = wy_r[1]; end
      2'd1:    begin dax = wx_r[1]; day = wy_r[1]; dbx = wx_r[2]; dby = wy_r[2]; end
      default: begin dax = wx_r[2]; day = wy_r[2]; dbx = px_r;    dby = py_r;    end
    endcase
  end

  scr_dist #(.COORD_BITS(CB), .DW(CB + 1), .RW(RW)) u_dist (
    .clk, .rst_n, .start(launch_r),
    .ax(dax), .ay(day), .bx(dbx), .by(dby),
    .done(dist_done), .root(dist_root)
  );

  assign su         = (step == '0) ? scr_pkg::STEP_W'(1) : step;
  assign trial      = n_r | (NW'(1) << k_r);
  assign sat_lim    = MW'(MAX_SEGMENTS) * MW'(su);
  assign trial_prod = MW'(trial) * MW'(su);
  assign lhs20      = (RW+5)'(dab_r) * (RW+5)'(20);
  assign rhs        = (RW+5)'(dbc_r) + (RW+5)'(dcd_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      held_r   <= 2'd0;
      lv_r     <= 1'b0;
      launch_r <= 1'b0;
      cache0_r <= '0;
      cache1_r <= '0;
      for (int j = 0; j < 3; j++) begin
        wx_r[j] <= '0;
        wy_r[j] <= '0;
      end
    end else begin
      launch_r <= 1'b0;
      unique case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            px_r <= sx;
            py_r <= sy;
            if (in_stroke_start) begin
              lv_r     <= 1'b0;
              cache0_r <= '0;
              cache1_r <= '0;
            end
            if (held_eff != 2'd3) begin
              wx_r[held_eff] <= sx;
              wy_r[held_eff] <= sy;
              held_r         <= held_eff + 2'd1;
              if (held_eff == 2'd0) begin
                cmd_r   <= {scr_pkg::CMD_EMIT, NW'(0), {(3*CB){1'b0}}, sx,
                            {(3*CB){1'b0}}, sy};
                state_r <= F_PUSH;
              end
            end else begin
              launch_r <= 1'b1;
              state_r  <= F_LEN;
              if (lv_r) begin
                dab_r <= cache0_r;
                dbc_r <= cache1_r;
                sel_r <= 2'd2;
              end else begin
                sel_r <= 2'd0;
              end
            end
          end
        end
        F_LEN: begin
          if (dist_done) begin
            case (sel_r)
              2'd0:    begin dab_r <= dist_root; sel_r <= 2'd1; launch_r <= 1'b1; end
              2'd1:    begin dbc_r <= dist_root; sel_r <= 2'd2; launch_r <= 1'b1; end
              default: begin dcd_r <= dist_root; state_r <= F_NSAT; end
            endcase
          end
        end
        F_NSAT: begin
          if (MW'(dbc_r) >= sat_lim) begin
            n_r     <= NW'(MAX_SEGMENTS);
            state_r <= F_DECIDE;
          end else begin
            n_r     <= '0;
            k_r     <= KW'(NW - 1);
            state_r <= F_NDIV;
          end
        end
        F_NDIV: begin
          if (trial_prod <= MW'(dbc_r)) n_r <= trial;
          if (k_r == '0) state_r <= F_DECIDE;
          else k_r <= k_r - 1'b1;
        end
        F_DECIDE: begin
          if (n_r != '0 && lhs20 > rhs)
            cmd_r <= {scr_pkg::CMD_INTERP, n_r, wx_r[0], wx_r[1], wx_r[2], px_r,
                      wy_r[0], wy_r[1], wy_r[2], py_r};
          else
            cmd_r <= {scr_pkg::CMD_EMIT, NW'(0), {(3*CB){1'b0}}, wx_r[2],
                      {(3*CB){1'b0}}, wy_r[2]};
          cache0_r <= dbc_r;
          cache1_r <= dcd_r;
          lv_r     <= 1'b1;
          wx_r[0]  <= wx_r[1]; wy_r[0] <= wy_r[1];
          wx_r[1]  <= wx_r[2]; wy_r[1] <= wy_r[2];
          wx_r[2]  <= px_r;    wy_r[2] <= py_r;
          state_r  <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign in_ready = (state_r == F_IDLE);
  assign q_push   = (state_r == F_PUSH) && !q_full;
  assign q_data   = cmd_r;

endmodule

// ===== design/scr_cmdq.sv =====
// ----------------------------------------------------------------------------
// scr_cmdq: command queue between front and back
// Small FIFO; each side stalls only on full or empty.
// ----------------------------------------------------------------------------
module scr_cmdq #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  assign rdata = mem_r[rp_r];
  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);

endmodule

// ===== design/scr_back.sv =====
// ----------------------------------------------------------------------------
// scr_back: point generator
// Runs one command: a single point, or n Catmull-Rom points through a
// shared multiplier, into the output register.
// ----------------------------------------------------------------------------
module scr_back #(
  parameter int COORD_BITS   = scr_pkg::COORD_BITS_DEF,
  parameter int MAX_SEGMENTS = scr_pkg::MAX_SEGMENTS_DEF,
  parameter int NW           = $clog2(MAX_SEGMENTS + 1),
  parameter int CMD_W        = 1 + NW + 8 * COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [CMD_W-1:0]             q_data,
  input  logic                         q_empty,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_point_x,
  output logic signed [COORD_BITS-1:0] out_point_y,
  output logic                         out_last_point
);

  localparam int CB  = COORD_BITS;
  localparam int WW  = scr_pkg::WGT_W;
  localparam int OW  = CB + 2;
  localparam int PW  = OW + WW;
  localparam int ACW = CB + 21;
  localparam int HW  = 52;
  localparam logic signed [ACW-1:0] RND  = ACW'(65536);
  localparam logic signed [ACW-18:0] CMAXW = (ACW-17)'((64'd1 << (CB - 1)) - 1);
  localparam logic signed [ACW-18:0] CMINW = -CMAXW - 1'b1;

  typedef enum logic [2:0] {B_IDLE, B_DIV, B_T2, B_T3, B_WGT, B_MAC, B_OUT} bstate_t;

  bstate_t               state_r;
  scr_pkg::cmd_kind_t    kind_r;
  logic [NW-1:0]         n_r, i_r;
  logic signed [CB-1:0]  cx_r [4];
  logic signed [CB-1:0]  cy_r [4];
  logic [NW:0]           rem_r;
  logic [16:0]           quo_r;
  logic [4:0]            dcnt_r;
  logic [NW-1:0]         r_r;
  logic [16:0]           t_r;
  logic [31:0]           t2_r;
  logic [47:0]           t3_r;
  logic signed [WW-1:0]  w_r [4];
  logic [2:0]            mstep_r;
  logic signed [ACW-1:0] acc_r;
  logic signed [CB-1:0]  rx_r, ry_r;
  logic                  ov_r, olast_r;
  logic signed [CB-1:0]  ox_r, oy_r;

  logic [NW:0]           rem_sh;
  logic signed [CB-1:0]  ca, cb_, cc, cd;
  logic signed [OW-1:0]  opnd;
  logic signed [PW-1:0]  prod;
  logic signed [ACW-1:0] acc_sum;
  logic signed [ACW-18:0] shr;
  logic signed [CB-1:0]  clamped;
  logic signed [HW-1:0]  h00, h10, h11, t3s, t2s, ts;
  logic                  can_load, fin, load_out;
  logic [NW:0]           r_add;

  assign rem_sh = {rem_r[NW-1:0], (dcnt_r == 5'd16)};

  // operands of the multiply-accumulate, x axis first
  always_comb begin
    if (mstep_r[2]) begin
      ca = cy_r[0]; cb_ = cy_r[1]; cc = cy_r[2]; cd = cy_r[3];
    end else begin
      ca = cx_r[0]; cb_ = cx_r[1]; cc = cx_r[2]; cd = cx_r[3];
    end
    case (mstep_r[1:0])
      2'd0:    opnd = OW'(cb_) <<< 1;
      2'd1:    opnd = OW'(cc) <<< 1;
      2'd2:    opnd = OW'(cc) - OW'(ca);
      default: opnd = OW'(cd) - OW'(cb_);
    endcase
  end

  assign prod    = PW'(opnd) * PW'(w_r[mstep_r[1:0]]);
  assign acc_sum = acc_r + ACW'(prod);
  assign shr     = (ACW-17)'((acc_sum + RND) >>> 17);
  assign clamped = (shr > CMAXW) ? CMAXW[CB-1:0] :
                   (shr < CMINW) ? CMINW[CB-1:0] : shr[CB-1:0];

  assign ts  = HW'(t_r[15:0]) <<< 32;
  assign t2s = HW'(t2_r) <<< 16;
  assign t3s = HW'(t3_r);
  assign h00 = (t3s <<< 1) - (t2s + (t2s <<< 1)) + (HW'(1) <<< 48);
  assign h10 = t3s - (t2s <<< 1) + ts;
  assign h11 = t3s - t2s;

  assign can_load = !ov_r || out_ready;
  assign load_out = (state_r == B_OUT) && can_load;
  assign fin      = (kind_r == scr_pkg::CMD_EMIT) || (i_r == n_r - 1'b1);
  assign r_add    = (NW+1)'(r_r) + (NW+1)'(rem_r[NW-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      ov_r    <= 1'b0;
    end else begin
      if (load_out) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            kind_r <= scr_pkg::cmd_kind_t'(q_data[CMD_W-1]);
            n_r    <= q_data[CMD_W-2 -: NW];
            for (int j = 0; j < 4; j++) begin
              cx_r[j] <= q_data[8*CB-1-CB*j -: CB];
              cy_r[j] <= q_data[4*CB-1-CB*j -: CB];
            end
            rx_r   <= q_data[5*CB-1 -: CB];
            ry_r   <= q_data[CB-1:0];
            i_r    <= '0;
            t_r    <= '0;
            r_r    <= '0;
            rem_r  <= '0;
            quo_r  <= '0;
            dcnt_r <= 5'd16;
            state_r <= (q_data[CMD_W-1] == scr_pkg::CMD_INTERP) ? B_DIV : B_OUT;
          end
        end
        B_DIV: begin
          // 65536 / n, one quotient bit a cycle; remainder kept for stepping t
          if (rem_sh >= (NW+1)'(n_r)) begin
            rem_r <= rem_sh - (NW+1)'(n_r);
            quo_r <= {quo_r[15:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[15:0], 1'b0};
          end
          dcnt_r <= dcnt_r - 1'b1;
          if (dcnt_r == 5'd0) state_r <= B_T2;
        end
        B_T2: begin
          t2_r    <= 32'(t_r[15:0] * t_r[15:0]);
          state_r <= B_T3;
        end
        B_T3: begin
          t3_r    <= 48'(t2_r * t_r[15:0]);
          state_r <= B_WGT;
        end
        B_WGT: begin
          w_r[0]  <= WW'((h00 + (HW'(1) <<< 31)) >>> 32);
          w_r[1]  <= WW'(65536) - WW'((h00 + (HW'(1) <<< 31)) >>> 32);
          w_r[2]  <= WW'((h10 + (HW'(1) <<< 31)) >>> 32);
          w_r[3]  <= WW'((h11 + (HW'(1) <<< 31)) >>> 32);
          mstep_r <= 3'd0;
          acc_r   <= '0;
          state_r <= B_MAC;
        end
        B_MAC: begin
          mstep_r <= mstep_r + 3'd1;
          if (mstep_r[1:0] == 2'd3) begin
            acc_r <= '0;
            if (mstep_r[2]) begin
              ry_r    <= clamped;
              state_r <= B_OUT;
            end else begin
              rx_r <= clamped;
            end
          end else begin
            acc_r <= acc_sum;
          end
        end
        B_OUT: begin
          if (can_load) begin
            ox_r    <= rx_r;
            oy_r    <= ry_r;
            olast_r <= fin;
            if (fin) begin
              state_r <= B_IDLE;
            end else begin
              i_r <= i_r + 1'b1;
              if (r_add >= (NW+1)'(n_r)) begin
                r_r <= NW'(r_add - (NW+1)'(n_r));
                t_r <= t_r + quo_r + 17'd1;
              end else begin
                r_r <= NW'(r_add);
                t_r <= t_r + quo_r;
              end
              state_r <= B_T2;
            end
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign q_pop          = (state_r == B_IDLE) && !q_empty;
  assign out_valid      = ov_r;
  assign out_point_x    = ox_r;
  assign out_point_y    = oy_r;
  assign out_last_point = olast_r;

endmodule

// ===== design/scr_checker.sv =====
// ----------------------------------------------------------------------------
// scr_checker: port-level checks for the stroke smoother
// Watches reset, output holding and the register port.
// ----------------------------------------------------------------------------
module scr_checker #(
  parameter int COORD_BITS = scr_pkg::COORD_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [COORD_BITS-1:0] out_point_x,
  input logic signed [COORD_BITS-1:0] out_point_y,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [2:0]                   paddr,
  input logic [31:0]                  pwdata,
  input logic [31:0]                  prdata,
  input logic                         pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_point_x) && $stable(out_point_y))
    else $error("stalled point changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("point shown right after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

  a_hpw_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && paddr[2] == scr_pkg::REG_HPW
    |=> (paddr[2] != scr_pkg::REG_HPW) || (prdata[11:0] == $past(pwdata[11:0])) ||
        $past(paddr[2]) != paddr[2] || (psel && penable && pwrite))
    else $error("half pen width readback mismatch");

endmodule

bind stroke_catmull_rom_smoother scr_checker #(.COORD_BITS(COORD_BITS)) u_scr_checker (
  .clk, .rst_n, .out_valid, .out_ready,
  .out_point_x, .out_point_y, .psel, .penable, .pwrite, .paddr,
  .pwdata, .prdata, .pready
);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for stroke_catmull_rom_smoother
// Sends pen strokes through the valid/ready input and predicts every path
// point in a local model of the smoother. Each point that leaves the block is
// checked against the oldest predicted point. The run covers directed corner
// cases, register sweeps, random strokes and a long output stall.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = scr_pkg::COORD_BITS_DEF;
  localparam int MAXSEG = scr_pkg::MAX_SEGMENTS_DEF;
  localparam longint CMAX = (64'sd1 <<< (CB - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;
  localparam int DRAIN_CYCLES = 400;   // covers three sqrt runs plus segment search

  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic                 last;
  } path_point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CB-1:0] in_sample_x = '0;
  logic signed [CB-1:0] in_sample_y = '0;
  logic in_stroke_start = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [CB-1:0] out_point_x;
  logic signed [CB-1:0] out_point_y;
  logic out_last_point;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  stroke_catmull_rom_smoother u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_sample_x(in_sample_x), .in_sample_y(in_sample_y),
    .in_stroke_start(in_stroke_start),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_point_x(out_point_x), .out_point_y(out_point_y),
    .out_last_point(out_last_point),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Smoother model state: register copies, sample window and cached lengths
  // ---------------------------------------------------------------------------
  longint hpw_q = scr_pkg::HPW_RESET;
  longint step_q = scr_pkg::STEP_RESET;
  longint win_x[3], win_y[3];
  int     held = 0;
  longint len_ab_c = 0, len_bc_c = 0;
  bit     lens_ok = 0;

  path_point_t pending_points[$];
  int mismatches = 0;
  int points_seen = 0;
  int samples_sent = 0;
  int stall_left = 0;  // receiver hold-off, counted down by the receiver
  int stall_req = 0;   // bumped by the pressure test
  int stall_ack = 0;

  function automatic longint clamp_coord(longint v);
    if (v > CMAX) return CMAX;
    if (v < CMIN) return CMIN;
    return v;
  endfunction

  // exact floor(sqrt(dx^2 + dy^2)); the sum stays below 2^42
  function automatic longint seg_length(longint ax, longint ay, longint bx, longint by);
    longint dx, dy, sq, root, cand;
    dx = bx - ax;
    dy = by - ay;
    sq = dx * dx + dy * dy;
    root = 0;
    for (int k = 21; k >= 0; k--) begin
      cand = root | (64'sd1 <<< k);
      if (cand * cand <= sq) root = cand;
    end
    return root;
  endfunction

  function automatic longint blend(longint a, longint b, longint c, longint d,
                                   longint w00, longint w01, longint w10, longint w11);
    longint acc;
    acc = 2 * b * w00 + 2 * c * w01 + (c - a) * w10 + (d - b) * w11;
    return clamp_coord((acc + 65536) >>> 17);
  endfunction

  function automatic void push_point(longint x, longint y, bit last);
    path_point_t p;
    p.x = x[CB-1:0];
    p.y = y[CB-1:0];
    p.last = last;
    pending_points.push_back(p);
  endfunction

  // one accepted pen sample -> expected path points
  function automatic void smooth_sample(logic signed [CB-1:0] sx, logic signed [CB-1:0] sy,
                                        bit start);
    longint px, py, ab, bc, cd, su, n, t, t2, t3, w00, w01, w10, w11;
    px = clamp_coord(longint'(sx) - hpw_q);
    py = clamp_coord(longint'(sy) - hpw_q);
    if (start) begin
      held = 0;
      lens_ok = 0;
      len_ab_c = 0;
      len_bc_c = 0;
    end
    if (held < 3) begin
      win_x[held] = px;
      win_y[held] = py;
      held++;
      if (held == 1) push_point(px, py, 1);
      return;
    end
    if (lens_ok) begin
      ab = len_ab_c;
      bc = len_bc_c;
    end else begin
      ab = seg_length(win_x[0], win_y[0], win_x[1], win_y[1]);
      bc = seg_length(win_x[1], win_y[1], win_x[2], win_y[2]);
    end
    cd = seg_length(win_x[2], win_y[2], px, py);
    len_ab_c = bc;
    len_bc_c = cd;
    lens_ok = 1;
    su = (step_q == 0) ? 1 : step_q;
    n = bc / su;
    if (n > MAXSEG) n = MAXSEG;
    if (n > 0 && 20 * ab > bc + cd) begin
      for (longint i = 0; i < n; i++) begin
        t = (i <<< 16) / n;
        t2 = t * t;
        t3 = t2 * t;
        w00 = (2 * t3 - 3 * (t2 <<< 16) + (64'sd1 <<< 48) + (64'sd1 <<< 31)) >>> 32;
        w01 = 65536 - w00;
        w10 = (t3 - 2 * (t2 <<< 16) + (t <<< 32) + (64'sd1 <<< 31)) >>> 32;
        w11 = (t3 - (t2 <<< 16) + (64'sd1 <<< 31)) >>> 32;
        push_point(blend(win_x[0], win_x[1], win_x[2], px, w00, w01, w10, w11),
                   blend(win_y[0], win_y[1], win_y[2], py, w00, w01, w10, w11),
                   i + 1 == n);
      end
    end else begin
      push_point(win_x[2], win_y[2], 1);
    end
    win_x[0] = win_x[1]; win_y[0] = win_y[1];
    win_x[1] = win_x[2]; win_y[1] = win_y[2];
    win_x[2] = px;       win_y[2] = py;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random ready pattern and point checker
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_req != stall_ack) begin
      // long hold-off asked for by the pressure test
      out_ready <= 1'b0;
      stall_ack <= stall_req;
      stall_left <= 3000;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 2) begin
      // occasional long hold-off
      out_ready <= 1'b0;
      stall_left <= $urandom_range(10, 60);
    end else if (($urandom_range(0, 99) < 25) && ($urandom_range(0, 3) != 0)) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    path_point_t want;
    if (rst_n && out_valid && out_ready) begin
      points_seen++;
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected point x=%0d y=%0d last=%0b", $time,
                   out_point_x, out_point_y, out_last_point);
      end else begin
        want = pending_points[0];
        pending_points.delete(0);
        if (want.x !== out_point_x || want.y !== out_point_y ||
            want.last !== out_last_point) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] point mismatch: exp x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                     $time, want.x, want.y, want.last,
                     out_point_x, out_point_y, out_last_point);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // valid stays high across back-to-back transactions; a gap lowers it
  task automatic send_sample(longint x, longint y, bit start, int gap);
    @(negedge clk);
    in_valid <= 1'b1;
    in_sample_x <= x[CB-1:0];
    in_sample_y <= y[CB-1:0];
    in_stroke_start <= start;
    do @(posedge clk); while (!in_ready);
    smooth_sample(x[CB-1:0], y[CB-1:0], start);
    samples_sent++;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // block idle: all points out, plus time for a sample that makes no point
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic reg_idx, longint value);
    wait_idle();
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value[31:0];
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (reg_idx == scr_pkg::REG_HPW) hpw_q = value & 12'hFFF;
    else step_q = value & 16'hFFFF;
  endtask

  // stroke of len samples as a random walk from (x0,y0)
  task automatic send_stroke(longint x0, longint y0, int len, int reach);
    longint x, y;
    x = x0;
    y = y0;
    for (int k = 0; k < len; k++) begin
      send_sample(x, y, k == 0, pick_gap());
      x = clamp_coord(x + $signed($urandom_range(0, 2 * reach)) - reach);
      y = clamp_coord(y + $signed($urandom_range(0, 2 * reach)) - reach);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    // most negative sample: offset saturates at the bottom of the range
    send_sample(CMIN, CMIN, 1, 0);
    // second sample only fills the window
    send_sample(CMIN + 5, CMIN + 9, 0, 0);
    // restart after two samples: window cleared mid-stroke
    send_sample(CMAX, CMAX, 1, 2);
    send_sample(CMAX - 1000, CMAX, 0, 0);
    send_sample(CMAX - 2000, CMAX - 500, 0, 0);
    // long jumps across the range: segment count saturates
    send_sample(0, CMAX, 0, 0);
    send_sample(CMIN, 0, 0, 1);
    send_sample(CMAX, CMIN, 0, 0);
    // short segments: zero interpolated points, c is emitted
    send_sample(10, 10, 1, 0);
    send_sample(20, 20, 0, 0);
    send_sample(30, 25, 0, 0);
    send_sample(40, 35, 0, 3);
    // tiny ab against long bc: sharp-corner rule falls back to c
    send_sample(1000, 1000, 1, 0);
    send_sample(1001, 1000, 0, 0);
    send_sample(5000, 9000, 0, 0);
    send_sample(9000, 1000, 0, 0);
    send_sample(9100, 1100, 0, 0);
    // smooth arc with several points per segment
    send_sample(0, 0, 1, 0);
    send_sample(800, 100, 0, 0);
    send_sample(1500, 500, 0, 0);
    send_sample(2000, 1200, 0, 0);
    send_sample(2200, 2000, 0, 0);
  endtask

  task automatic test_config_sweep();
    longint hpw_set[4] = '{0, 4095, 1, 16};
    longint step_set[5] = '{1, 65535, 0, 300, 64};
    for (int k = 0; k < 5; k++) begin
      write_reg(scr_pkg::REG_HPW, hpw_set[k % 4]);
      write_reg(scr_pkg::REG_STEP, step_set[k]);
      send_stroke(CMIN + 100, $signed($urandom_range(0, 2000)) - 1000, 6, 3000);
      send_stroke($signed($urandom_range(0, 4000)) - 2000, 0, 5, 400);
    end
  endtask

  task automatic test_random(int target);
    int start_cnt;
    int r;
    start_cnt = samples_sent;
    while (samples_sent - start_cnt < target) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        // well-formed stroke, mostly modest reach
        send_stroke($signed($urandom_range(0, 200000)) - 100000,
                    $signed($urandom_range(0, 200000)) - 100000,
                    $urandom_range(4, 20), 1 << $urandom_range(3, 11));
      end else if (r < 90) begin
        // full-range noise, every bit of both coordinates
        send_stroke($signed($urandom_range(0, 2 * CMAX + 1)) + CMIN,
                    $signed($urandom_range(0, 2 * CMAX + 1)) + CMIN,
                    $urandom_range(1, 6), 1 << 19);
      end else begin
        // broken strokes restarted early
        send_stroke($signed($urandom_range(0, 4000)), $signed($urandom_range(0, 4000)),
                    $urandom_range(1, 3), 500);
      end
      if ($urandom_range(0, 99) < 8) begin
        write_reg(scr_pkg::REG_STEP, $urandom_range(8, 512));
        write_reg(scr_pkg::REG_HPW, $urandom_range(0, 4095));
      end
    end
  endtask

  task automatic test_backpressure();
    write_reg(scr_pkg::REG_STEP, 16);
    write_reg(scr_pkg::REG_HPW, 16);
    @(negedge clk);
    stall_req++;
    // long straight stroke: many points, so the queue fills and in_ready drops
    send_sample(0, 0, 1, 0);
    for (int k = 1; k < 14; k++)
      send_sample(k * 1200, k * 700 + $urandom_range(0, 40), 0, 0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_config_sweep();
    test_backpressure();
    write_reg(scr_pkg::REG_STEP, 64);
    test_random(300);
    wait_idle();
    $display("covered %0d pen samples and %0d path points, incl. register sweeps",
             samples_sent, points_seen);
    $display("and a long output stall; %0d mismatches", mismatches);
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("timeout with %0d points outstanding", pending_points.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
design/scr_pkg.sv
design/scr_dist.sv
design/scr_front.sv
design/scr_cmdq.sv
design/scr_back.sv
design/stroke_catmull_rom_smoother.sv
design/scr_checker.sv
sim/tb_top.sv
